[src/srdab_pkg.sv]
// Shared constants and types for the soft-round dab pixel pipeline.
package srdab_pkg;

  localparam int MAX_DIAMETER = 4096;
  localparam int R_MAX        = MAX_DIAMETER / 2;
  localparam int DIAM_W       = $clog2(MAX_DIAMETER) + 1;
  localparam int RAD_W        = $clog2(R_MAX) + 1;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_BRUSH_SIZE     = 3'd0;
  localparam logic [2:0] REG_HARDNESS       = 3'd1;
  localparam logic [2:0] REG_FLOW           = 3'd2;
  localparam logic [2:0] REG_BRUSH_COLOR    = 3'd3;
  localparam logic [2:0] REG_DEFAULT_ERASER = 3'd4;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [32:0] NO_DAB_LIMIT = 33'd1310720;   // 2*num < 5*2^19
  localparam logic [29:0] DIV5_MUL_32  = 30'd858993460; // ceil(2^32/5)
  localparam logic [15:0] DIV5_MUL_18  = 16'd52429;     // ceil(2^18/5)

  localparam int SQ_STEPS  = 28; // result bits of the distance root
  localparam int DIV_STEPS = 16; // quotient bits of each divider

  // Side data that travels with a pixel through the pipeline
  typedef struct packed {
    logic [DIAM_W-1:0] diam;
    logic              no_dab;
    logic              zero;
    logic              full;
    logic              eraser;
    logic [7:0]        solid;
    logic [33:0]       pf;
    logic [26:0]       r16;
  } side_t;

endpackage

[src/soft_round_dab_pixel_core.sv]
// Soft-round brush dab pixel core: one RGBA pixel per accepted coordinate.
// Each pixel passes stages 1-3, the root, both dividers, then the mask and output stages.
// Throughput: one pixel per cycle; the 28-step distance root and two 16-step
// dividers run one step per stage. An output stall holds every stage and in_tready.
// Reset (rst_n low, synchronous) clears all valid bits and loads the
// register defaults: size 16.0, hardness 55706, flow 1.0, color 0xFF000000.
module soft_round_dab_pixel_core
  import srdab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pixel_x[11:0], pixel_y[23:12], pressure[40:24], zero pad
  input  logic        in_tuser,   // eraser_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24],
                                  // dab_diameter[44:32], zero pad
  output logic        out_tuser,  // no_dab
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic [15:0] brush_size_r;
  logic [16:0] hardness_r;
  logic [16:0] flow_r;
  logic [31:0] brush_color_r;
  logic        default_eraser_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brush_size_r     <= 16'd256;
      hardness_r       <= 17'd55706;
      flow_r           <= ONE_Q16;
      brush_color_r    <= 32'hFF000000;
      default_eraser_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BRUSH_SIZE:     brush_size_r     <= cfg_data[15:0];
        REG_HARDNESS:       hardness_r       <= cfg_data[16:0];
        REG_FLOW:           flow_r           <= cfg_data[16:0];
        REG_BRUSH_COLOR:    brush_color_r    <= cfg_data;
        REG_DEFAULT_ERASER: default_eraser_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturated register views
  logic [15:0] size_eff;
  logic [16:0] hd_eff;
  logic [16:0] flow_eff;
  logic [16:0] span;
  assign size_eff = (brush_size_r < 16'd16) ? 16'd16 : brush_size_r;
  assign hd_eff   = (hardness_r > ONE_Q16) ? ONE_Q16 : hardness_r;
  assign flow_eff = (flow_r > ONE_Q16) ? ONE_Q16 : flow_r;
  assign span     = ONE_Q16 - hd_eff;

  // Global advance: every stage moves when the output register can take data
  logic adv;
  logic out_vld_r;
  assign adv       = ~out_vld_r | out_tready;
  assign in_tready = adv;

  // Stage 1: pressure fix-up, radius numerator, color alpha times pressure
  logic [11:0] px_in, py_in;
  logic [16:0] p_in, p_fix;
  assign px_in = in_tdata[11:0];
  assign py_in = in_tdata[23:12];
  assign p_in  = in_tdata[40:24];
  assign p_fix = (p_in == 17'd0 || p_in > ONE_Q16) ? ONE_Q16 : p_in;

  logic        s1_vld_r;
  logic [11:0] s1_px_r, s1_py_r;
  logic [16:0] s1_p_r;
  logic        s1_er_r;
  logic [32:0] s1_num_r;
  logic [24:0] s1_ap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (adv) s1_vld_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r  <= px_in;
      s1_py_r  <= py_in;
      s1_p_r   <= p_fix;
      s1_er_r  <= in_tuser | default_eraser_r;
      s1_num_r <= 33'(size_eff * (p_fix + 17'd16384));
      s1_ap_r  <= 25'(brush_color_r[31:24] * p_fix);
    end
  end

  // Stage 2: reciprocal products for radius ceiling and R16, flow products
  logic [14:0] q19;
  assign q19 = 15'(s1_num_r[32:19]) + 15'(|s1_num_r[18:0]);

  logic        s2_vld_r;
  logic [11:0] s2_px_r, s2_py_r;
  logic        s2_er_r;
  logic        s2_nodab_r;
  logic [30:0] s2_q5p_r;
  logic [26:0] s2_r16_r;
  logic [41:0] s2_apf_r;
  logic [33:0] s2_pf_r;
  logic [59:0] r16_prod;
  assign r16_prod = s1_num_r[32:3] * DIV5_MUL_32;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (adv) s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_px_r    <= s1_px_r;
      s2_py_r    <= s1_py_r;
      s2_er_r    <= s1_er_r;
      s2_nodab_r <= s1_num_r < NO_DAB_LIMIT;
      s2_q5p_r   <= 31'((q19 + 15'd4) * DIV5_MUL_18);
      s2_r16_r   <= r16_prod[58:32];
      s2_apf_r   <= 42'(s1_ap_r * flow_eff);
      s2_pf_r    <= 34'(s1_p_r * flow_eff);
    end
  end

  // Stage 3: clamp radius, square size, offsets from the center
  logic [12:0]       q5;
  logic [RAD_W-1:0]  rad;
  logic [DIAM_W-1:0] diam;
  logic [13:0]       sxd, syd;
  logic [13:0]       sxa, sya;
  logic [42:0]       solid_sum;
  assign q5   = s2_q5p_r[30:18];
  assign rad  = (q5 == 13'd0) ? RAD_W'(1) :
                (q5 > 13'(R_MAX)) ? RAD_W'(R_MAX) : RAD_W'(q5);
  assign diam = {rad, 1'b0};
  assign sxd  = {1'b0, s2_px_r, 1'b1} - 14'(diam);
  assign syd  = {1'b0, s2_py_r, 1'b1} - 14'(diam);
  assign sxa  = sxd[13] ? (14'd0 - sxd) : sxd;
  assign sya  = syd[13] ? (14'd0 - syd) : syd;
  assign solid_sum = {1'b0, s2_apf_r} + 43'h0_0080000000;

  logic        s3_vld_r;
  logic [11:0] s3_dx_r, s3_dy_r;
  side_t       s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (adv) s3_vld_r <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_dx_r          <= sxa[11:0];
      s3_dy_r          <= sya[11:0];
      s3_side_r.diam   <= s2_nodab_r ? '0 : diam;
      s3_side_r.no_dab <= s2_nodab_r;
      s3_side_r.zero   <= s2_nodab_r || (13'(s2_px_r) >= diam) || (13'(s2_py_r) >= diam);
      s3_side_r.full   <= 1'b0;
      s3_side_r.eraser <= s2_er_r;
      s3_side_r.solid  <= (solid_sum[42:32] > 11'd255) ? 8'd255 : solid_sum[39:32];
      s3_side_r.pf     <= s2_pf_r;
      s3_side_r.r16    <= s2_r16_r;
    end
  end

  // Stage 4: squared distance, loaded into the root pipeline head
  logic [55:0] sq_v_r    [0:SQ_STEPS];
  logic [27:0] sq_root_r [0:SQ_STEPS];
  logic [29:0] sq_rem_r  [0:SQ_STEPS];
  side_t       sq_side_r [0:SQ_STEPS];
  logic        sq_vld_r  [0:SQ_STEPS];
  logic [24:0] dist2;
  assign dist2 = 25'(s3_dx_r * s3_dx_r) + 25'(s3_dy_r * s3_dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else if (adv) sq_vld_r[0] <= s3_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v_r[0]    <= {1'b0, dist2, 30'd0};
      sq_root_r[0] <= '0;
      sq_rem_r[0]  <= '0;
      sq_side_r[0] <= s3_side_r;
    end
  end

  // Root stages: one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [31:0] sh, trial, diff;
    logic        ge;
    assign sh    = {sq_rem_r[k], sq_v_r[k][55:54]};
    assign trial = {2'b00, sq_root_r[k], 2'b01};
    assign diff  = sh - trial;
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[k+1] <= 1'b0;
      else if (adv) sq_vld_r[k+1] <= sq_vld_r[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v_r[k+1]    <= {sq_v_r[k][53:0], 2'b00};
        sq_root_r[k+1] <= {sq_root_r[k][26:0], ge};
        sq_rem_r[k+1]  <= ge ? diff[29:0] : sh[29:0];
        sq_side_r[k+1] <= sq_side_r[k];
      end
    end
  end

  // Distance over radius: range check, then one quotient bit per stage
  logic [26:0] dv_rem_r  [0:DIV_STEPS];
  logic [15:0] dv_q_r    [0:DIV_STEPS];
  side_t       dv_side_r [0:DIV_STEPS];
  logic        dv_vld_r  [0:DIV_STEPS];
  logic [27:0] d16;
  side_t       dv_head;
  assign d16 = sq_root_r[SQ_STEPS];
  always_comb begin
    dv_head      = sq_side_r[SQ_STEPS];
    dv_head.zero = dv_head.zero | (d16 >= {1'b0, dv_head.r16});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (adv) dv_vld_r[0] <= sq_vld_r[SQ_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0]  <= d16[26:0];
      dv_q_r[0]    <= '0;
      dv_side_r[0] <= dv_head;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_tdiv
    logic [27:0] sh, diff;
    logic        ge;
    assign sh   = {dv_rem_r[j], 1'b0};
    assign diff = sh - {1'b0, dv_side_r[j].r16};
    assign ge   = sh >= {1'b0, dv_side_r[j].r16};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[j+1] <= 1'b0;
      else if (adv) dv_vld_r[j+1] <= dv_vld_r[j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[j+1]  <= ge ? diff[26:0] : sh[26:0];
        dv_q_r[j+1]    <= {dv_q_r[j][14:0], ge};
        dv_side_r[j+1] <= dv_side_r[j];
      end
    end
  end

  // Falloff: solid core test, then (t - hardness) / (1 - hardness)
  logic [16:0] mk_rem_r  [0:DIV_STEPS];
  logic [15:0] mk_q_r    [0:DIV_STEPS];
  side_t       mk_side_r [0:DIV_STEPS];
  logic        mk_vld_r  [0:DIV_STEPS];
  logic [16:0] t16;
  side_t       mk_head;
  assign t16 = {1'b0, dv_q_r[DIV_STEPS]};
  always_comb begin
    mk_head      = dv_side_r[DIV_STEPS];
    mk_head.full = t16 <= hd_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mk_vld_r[0] <= 1'b0;
    else if (adv) mk_vld_r[0] <= dv_vld_r[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mk_rem_r[0]  <= t16 - hd_eff;
      mk_q_r[0]    <= '0;
      mk_side_r[0] <= mk_head;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_mdiv
    logic [17:0] sh, diff;
    logic        ge;
    assign sh   = {mk_rem_r[j], 1'b0};
    assign diff = sh - {1'b0, span};
    assign ge   = sh >= {1'b0, span};

    always_ff @(posedge clk) begin
      if (!rst_n) mk_vld_r[j+1] <= 1'b0;
      else if (adv) mk_vld_r[j+1] <= mk_vld_r[j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        mk_rem_r[j+1]  <= ge ? diff[16:0] : sh[16:0];
        mk_q_r[j+1]    <= {mk_q_r[j][14:0], ge};
        mk_side_r[j+1] <= mk_side_r[j];
      end
    end
  end

  // Mask stage: scale solid alpha and pressure-flow by the mask
  logic [16:0] mask;
  side_t       mk_tail;
  assign mk_tail = mk_side_r[DIV_STEPS];
  assign mask    = mk_tail.full ? ONE_Q16 : (ONE_Q16 - {1'b0, mk_q_r[DIV_STEPS]});

  logic        m1_vld_r;
  logic [24:0] m1_sm_r;
  logic [50:0] m1_pfm_r;
  side_t       m1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_vld_r <= 1'b0;
    else if (adv) m1_vld_r <= mk_vld_r[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sm_r   <= 25'(mk_tail.solid * mask);
      m1_pfm_r  <= 51'(mk_tail.pf * mask);
      m1_side_r <= mk_tail;
    end
  end

  // Output stage: round, saturate, pick a blank, paint or eraser pixel
  logic [25:0] a_sum;
  logic [7:0]  a_paint;
  logic [59:0] e_sum;
  logic [7:0]  a_erase;
  logic        blank;
  assign a_sum   = {1'b0, m1_sm_r} + 26'd32768;
  assign a_paint = (a_sum[25:16] > 10'd255) ? 8'd255 : a_sum[23:16];
  assign e_sum   = ({1'b0, m1_pfm_r, 8'd0} - {9'd0, m1_pfm_r}) + (60'd1 << 47);
  assign a_erase = (e_sum[59:48] > 12'd255) ? 8'd255 : e_sum[55:48];
  assign blank   = m1_side_r.zero || (a_paint == 8'd0);

  logic [31:0]       out_rgba_r;
  logic [DIAM_W-1:0] out_diam_r;
  logic              out_nodab_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= m1_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_diam_r  <= m1_side_r.diam;
      out_nodab_r <= m1_side_r.no_dab;
      if (blank) begin
        out_rgba_r <= '0;
      end else if (m1_side_r.eraser) begin
        out_rgba_r <= {a_erase, 24'd0};
      end else begin
        out_rgba_r <= {a_paint, brush_color_r[7:0], brush_color_r[15:8],
                       brush_color_r[23:16]};
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(48 - 32 - DIAM_W)'(0), out_diam_r, out_rgba_r};
  assign out_tuser  = out_nodab_r;

endmodule
